@@ sv/cbb_pkg.sv @@
// ----------------------------------------------------------------------------
// cbb_pkg
// Shared types and constants of the cross blur byte stream filter.
// ----------------------------------------------------------------------------
package cbb_pkg;

    localparam int MAX_ROW_BYTES = 4096;
    localparam int MAX_ROWS      = 4096;
    localparam int CHANNEL_STEP  = 3;

    localparam int BYTE_W    = 8;
    localparam int COL_W     = $clog2(MAX_ROW_BYTES);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int SIZE_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = 11;
    localparam int CNT_W     = 3;
    localparam int NUM_SLOTS = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd1;

    typedef logic [BYTE_W-1:0] byte_t;

    // result kinds of one transaction, in delivery order
    typedef enum logic [2:0] {
        SLOT_UP,
        SLOT_LAST,
        SLOT_TAIL2,
        SLOT_TAIL1,
        SLOT_TAIL0
    } slot_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
    } mean_in_t;

endpackage

@@ sv/cbb_cell.sv @@
// ----------------------------------------------------------------------------
// cbb_cell
// One window cell: holds a byte and passes it to its neighbor on each shift.
// ----------------------------------------------------------------------------
module cbb_cell (
    input  logic          aclk,
    input  logic          shift_en,
    input  cbb_pkg::byte_t data_in,
    output cbb_pkg::byte_t data_out
);

    cbb_pkg::byte_t data_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= data_in;
        end
    end

    assign data_out = data_reg;

endmodule

@@ sv/cbb_line_ram.sv @@
// ----------------------------------------------------------------------------
// cbb_line_ram
// Line store: one write port, one registered read port, read before write.
// ----------------------------------------------------------------------------
module cbb_line_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/cbb_mean.sv @@
// ----------------------------------------------------------------------------
// cbb_mean
// Truncated mean of one to five bytes' sum, by shift or reciprocal multiply.
// ----------------------------------------------------------------------------
module cbb_mean (
    input  cbb_pkg::mean_in_t mean_in,
    output cbb_pkg::byte_t    mean_out
);

    localparam int MUL_W   = 12;
    localparam int PROD_W  = cbb_pkg::SUM_W + MUL_W;
    localparam int DIV3_SH = 13;
    localparam int DIV5_SH = 14;
    localparam logic [PROD_W-1:0] DIV3_MUL = PROD_W'(2731);
    localparam logic [PROD_W-1:0] DIV5_MUL = PROD_W'(3277);

    logic [PROD_W-1:0] prod3;
    logic [PROD_W-1:0] prod5;

    assign prod3 = PROD_W'(mean_in.sum) * DIV3_MUL;
    assign prod5 = PROD_W'(mean_in.sum) * DIV5_MUL;

    always_comb begin
        case (mean_in.cnt)
            3'd1:    mean_out = mean_in.sum[7:0];
            3'd2:    mean_out = mean_in.sum[8:1];
            3'd3:    mean_out = prod3[DIV3_SH +: cbb_pkg::BYTE_W];
            3'd4:    mean_out = mean_in.sum[9:2];
            3'd5:    mean_out = prod5[DIV5_SH +: cbb_pkg::BYTE_W];
            default: mean_out = '0;
        endcase
    end

endmodule

@@ sv/cross_blur_byte_stream.sv @@
// ----------------------------------------------------------------------------
// cross_blur_byte_stream
// Five-point cross mean blur over a row-major interleaved BGR byte stream.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one image byte per transaction, row-major, no row padding.
//   m_ channel: blurred bytes with their row and column; m_end_of_image marks
//   the last result of an image. Results of row r leave as row r+1 arrives;
//   the last row follows three bytes behind and its tail leaves on the final
//   byte.
//   cfg: index 0 row bytes, 1 row count; writing 0 or 1 restarts the image.
// order and throughput
//   a byte waits in the work stage; its result is registered for m_valid.
//   one byte per cycle on all rows but the last while the receiver keeps up;
//   on the last row a byte waits for its results to leave the single result
//   register, that gives one result per cycle while m_ready is high.
//   line stores are two 4096 x 8 memories plus a copy for the look-ahead read.
// reset and stall
//   reset clears counters and handshake state and loads 4096 x 4096; the line
//   stores are not cleared. A stalled receiver holds the result; a byte that
//   has a result to give then waits in the work stage with s_ready low.
// ----------------------------------------------------------------------------
module cross_blur_byte_stream (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [cbb_pkg::BYTE_W-1:0]      s_pixel_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cbb_pkg::BYTE_W-1:0]      m_blurred_byte,
    output logic [cbb_pkg::ROW_W-1:0]       m_out_row,
    output logic [cbb_pkg::COL_W-1:0]       m_out_column,
    output logic                            m_end_of_image,
    input  logic                            cfg_wr_en,
    input  logic [cbb_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [cbb_pkg::SIZE_W-1:0]      cfg_wr_data
);

    localparam int SIZE_W = cbb_pkg::SIZE_W;
    localparam int COL_W  = cbb_pkg::COL_W;
    localparam int ROW_W  = cbb_pkg::ROW_W;
    localparam int CNT_W  = cbb_pkg::CNT_W;
    localparam int SUM_W  = cbb_pkg::SUM_W;
    localparam int NSLOT  = cbb_pkg::NUM_SLOTS;
    localparam int STEP   = cbb_pkg::CHANNEL_STEP;
    localparam int PX_CELLS    = 2 * STEP;
    localparam int ABOVE_CELLS = STEP;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // configuration
    logic [SIZE_W-1:0] width_reg, width_next;
    logic [SIZE_W-1:0] rows_reg, rows_next;
    logic              cfg_hit;

    // input side counters
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SIZE_W-1:0] col_inc, row_inc;
    logic              last_a, final_a, s_acc;
    logic [NSLOT-1:0]  pend_a;
    logic [COL_W-1:0]  ahead_addr;

    // work stage
    logic              b_valid_reg, b_valid_next;
    logic [NSLOT-1:0]  b_pend_reg, b_pend_next;
    cbb_pkg::byte_t    b_px_reg;
    logic [COL_W-1:0]  b_col_reg;
    logic [ROW_W-1:0]  b_row_reg;
    logic              b_final_reg;
    logic              b_hit_c_reg, b_hit_a_reg;
    cbb_pkg::byte_t    b_fwd_px_reg, b_fwd_above_reg;
    cbb_pkg::byte_t    rd_newer, rd_older, rd_ahead;
    cbb_pkg::byte_t    above_b, older_b, ahead_b;
    logic              b_fire, out_ready, out_load;
    cbb_pkg::slot_t    sel;
    logic [NSLOT-1:0]  sel_mask, pend_rest;

    // window taps, index 0 is the byte in the work stage
    cbb_pkg::byte_t    px_tap    [PX_CELLS+1];
    cbb_pkg::byte_t    above_tap [ABOVE_CELLS+1];

    // result selection
    cbb_pkg::byte_t    op [NSLOT];
    logic [CNT_W-1:0]  cnt;
    logic [ROW_W-1:0]  res_row;
    logic [COL_W-1:0]  res_col;
    logic              has_up, up2, ge3, ge4, ge5, ge6, ahead_ok;
    cbb_pkg::mean_in_t res_mean;

    // result register
    logic              out_valid_reg, out_valid_next;
    cbb_pkg::mean_in_t out_mean_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic              out_end_reg;

    // ------------------------------------------------------------------
    always_comb begin
        width_next = width_reg;
        rows_next  = rows_reg;
        cfg_hit    = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                cbb_pkg::CFG_ROW_BYTES: begin
                    width_next = clamp_size(cfg_wr_data, SIZE_W'(cbb_pkg::MAX_ROW_BYTES));
                    cfg_hit    = 1'b1;
                end
                cbb_pkg::CFG_ROW_COUNT: begin
                    rows_next = clamp_size(cfg_wr_data, SIZE_W'(cbb_pkg::MAX_ROWS));
                    cfg_hit   = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    assign s_ready    = !b_valid_reg || b_fire;
    assign s_acc      = s_valid && s_ready;
    assign col_inc    = {1'b0, col_reg} + SIZE_W'(1);
    assign row_inc    = {1'b0, row_reg} + SIZE_W'(1);
    assign last_a     = (row_inc == rows_reg);
    assign final_a    = last_a && (col_inc == width_reg);
    assign ahead_addr = col_reg + COL_W'(STEP);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end else if (s_acc) begin
            if (final_a) begin
                col_next = '0;
                row_next = '0;
            end else if (col_inc >= width_reg) begin
                col_next = '0;
                row_next = row_inc[ROW_W-1:0];
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_comb begin
        pend_a             = '0;
        pend_a[cbb_pkg::SLOT_UP]    = (row_reg != '0);
        pend_a[cbb_pkg::SLOT_LAST]  = last_a && (col_reg >= COL_W'(STEP));
        pend_a[cbb_pkg::SLOT_TAIL2] = final_a && (col_reg >= COL_W'(2));
        pend_a[cbb_pkg::SLOT_TAIL1] = final_a && (col_reg >= COL_W'(1));
        pend_a[cbb_pkg::SLOT_TAIL0] = final_a;
    end

    // ------------------------------------------------------------------
    // line stores, written when the work stage retires a byte
    cbb_line_ram #(.DEPTH(cbb_pkg::MAX_ROW_BYTES), .WIDTH(cbb_pkg::BYTE_W)) u_newer_line (
        .aclk    (aclk),
        .wr_en   (b_fire),
        .wr_addr (b_col_reg),
        .wr_data (b_px_reg),
        .rd_en   (s_acc),
        .rd_addr (col_reg),
        .rd_data (rd_newer)
    );

    cbb_line_ram #(.DEPTH(cbb_pkg::MAX_ROW_BYTES), .WIDTH(cbb_pkg::BYTE_W)) u_ahead_line (
        .aclk    (aclk),
        .wr_en   (b_fire),
        .wr_addr (b_col_reg),
        .wr_data (b_px_reg),
        .rd_en   (s_acc),
        .rd_addr (ahead_addr),
        .rd_data (rd_ahead)
    );

    cbb_line_ram #(.DEPTH(cbb_pkg::MAX_ROW_BYTES), .WIDTH(cbb_pkg::BYTE_W)) u_older_line (
        .aclk    (aclk),
        .wr_en   (b_fire),
        .wr_addr (b_col_reg),
        .wr_data (above_b),
        .rd_en   (s_acc),
        .rd_addr (col_reg),
        .rd_data (rd_older)
    );

    // bypass of the write that retires in the same cycle as the read
    assign above_b = b_hit_c_reg ? b_fwd_px_reg    : rd_newer;
    assign older_b = b_hit_c_reg ? b_fwd_above_reg : rd_older;
    assign ahead_b = b_hit_a_reg ? b_fwd_px_reg    : rd_ahead;

    // ------------------------------------------------------------------
    // cell chains
    assign px_tap[0]    = b_px_reg;
    assign above_tap[0] = above_b;

    for (genvar k = 0; k < PX_CELLS; k++) begin : g_px_cell
        cbb_cell u_cell (
            .aclk     (aclk),
            .shift_en (b_fire),
            .data_in  (px_tap[k]),
            .data_out (px_tap[k+1])
        );
    end

    for (genvar k = 0; k < ABOVE_CELLS; k++) begin : g_above_cell
        cbb_cell u_cell (
            .aclk     (aclk),
            .shift_en (b_fire),
            .data_in  (above_tap[k]),
            .data_out (above_tap[k+1])
        );
    end

    // ------------------------------------------------------------------
    always_comb begin
        sel = cbb_pkg::SLOT_TAIL0;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (b_pend_reg[i]) begin
                sel = cbb_pkg::slot_t'(3'(i));
            end
        end
    end

    assign sel_mask  = NSLOT'(1) << sel;
    assign pend_rest = b_pend_reg & ~sel_mask;
    assign out_ready = !out_valid_reg || m_ready;
    assign out_load  = b_valid_reg && (b_pend_reg != '0) && out_ready;
    assign b_fire    = b_valid_reg && ((b_pend_reg == '0) || (out_ready && pend_rest == '0));

    assign has_up   = (b_row_reg != '0);
    assign up2      = (b_row_reg >= ROW_W'(2));
    assign ge3      = (b_col_reg >= COL_W'(STEP));
    assign ge4      = (b_col_reg >= COL_W'(STEP + 1));
    assign ge5      = (b_col_reg >= COL_W'(STEP + 2));
    assign ge6      = (b_col_reg >= COL_W'(2 * STEP));
    assign ahead_ok = (({1'b0, b_col_reg} + SIZE_W'(STEP)) < width_reg);

    always_comb begin
        for (int i = 0; i < NSLOT; i++) begin
            op[i] = '0;
        end
        cnt     = '0;
        res_row = b_row_reg;
        res_col = b_col_reg;
        case (sel)
            cbb_pkg::SLOT_UP: begin
                op[0]   = above_tap[0];
                op[1]   = px_tap[0];
                op[2]   = up2      ? older_b            : '0;
                op[3]   = ge3      ? above_tap[STEP]    : '0;
                op[4]   = ahead_ok ? ahead_b            : '0;
                cnt     = CNT_W'(2) + CNT_W'(up2) + CNT_W'(ge3) + CNT_W'(ahead_ok);
                res_row = b_row_reg - ROW_W'(1);
            end
            cbb_pkg::SLOT_LAST: begin
                op[0]   = px_tap[STEP];
                op[1]   = px_tap[0];
                op[2]   = has_up ? above_tap[STEP] : '0;
                op[3]   = ge6    ? px_tap[2*STEP]  : '0;
                cnt     = CNT_W'(2) + CNT_W'(has_up) + CNT_W'(ge6);
                res_col = b_col_reg - COL_W'(STEP);
            end
            cbb_pkg::SLOT_TAIL2: begin
                op[0]   = px_tap[2];
                op[1]   = has_up ? above_tap[2]    : '0;
                op[2]   = ge5    ? px_tap[STEP+2]  : '0;
                cnt     = CNT_W'(1) + CNT_W'(has_up) + CNT_W'(ge5);
                res_col = b_col_reg - COL_W'(2);
            end
            cbb_pkg::SLOT_TAIL1: begin
                op[0]   = px_tap[1];
                op[1]   = has_up ? above_tap[1]    : '0;
                op[2]   = ge4    ? px_tap[STEP+1]  : '0;
                cnt     = CNT_W'(1) + CNT_W'(has_up) + CNT_W'(ge4);
                res_col = b_col_reg - COL_W'(1);
            end
            cbb_pkg::SLOT_TAIL0: begin
                op[0]   = px_tap[0];
                op[1]   = has_up ? above_tap[0]    : '0;
                op[2]   = ge3    ? px_tap[STEP]    : '0;
                cnt     = CNT_W'(1) + CNT_W'(has_up) + CNT_W'(ge3);
            end
            default: begin
                cnt = '0;
            end
        endcase
    end

    assign res_mean.sum = SUM_W'(op[0]) + SUM_W'(op[1]) + SUM_W'(op[2])
                        + SUM_W'(op[3]) + SUM_W'(op[4]);
    assign res_mean.cnt = cnt;

    // ------------------------------------------------------------------
    always_comb begin
        b_valid_next = b_valid_reg;
        b_pend_next  = b_pend_reg;
        if (s_acc) begin
            b_valid_next = 1'b1;
            b_pend_next  = pend_a;
        end else begin
            if (b_fire) begin
                b_valid_next = 1'b0;
            end
            if (out_load) begin
                b_pend_next = pend_rest;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= SIZE_W'(cbb_pkg::MAX_ROW_BYTES);
            rows_reg      <= SIZE_W'(cbb_pkg::MAX_ROWS);
            col_reg       <= '0;
            row_reg       <= '0;
            b_valid_reg   <= 1'b0;
            b_pend_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            width_reg     <= width_next;
            rows_reg      <= rows_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            b_valid_reg   <= b_valid_next;
            b_pend_reg    <= b_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            b_px_reg        <= s_pixel_byte;
            b_col_reg       <= col_reg;
            b_row_reg       <= row_reg;
            b_final_reg     <= final_a;
            b_hit_c_reg     <= b_fire && (b_col_reg == col_reg);
            b_hit_a_reg     <= b_fire && (b_col_reg == ahead_addr);
            b_fwd_px_reg    <= b_px_reg;
            b_fwd_above_reg <= above_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_mean_reg <= res_mean;
            out_row_reg  <= res_row;
            out_col_reg  <= res_col;
            out_end_reg  <= b_final_reg && (pend_rest == '0);
        end
    end

    cbb_mean u_mean (
        .mean_in  (out_mean_reg),
        .mean_out (m_blurred_byte)
    );

    assign m_valid        = out_valid_reg;
    assign m_out_row      = out_row_reg;
    assign m_out_column   = out_col_reg;
    assign m_end_of_image = out_end_reg;

endmodule

@@ sv/cbb_checker.sv @@
// ----------------------------------------------------------------------------
// cbb_checker
// Port level checks of the cross blur byte stream filter, bound to the top.
// ----------------------------------------------------------------------------
module cbb_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [cbb_pkg::BYTE_W-1:0]  m_blurred_byte,
    input logic [cbb_pkg::ROW_W-1:0]   m_out_row,
    input logic [cbb_pkg::COL_W-1:0]   m_out_column,
    input logic                        m_end_of_image
);

    // reset empties the result register
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // stalled transaction stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped while stalled");

    a_hold_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_blurred_byte) && $stable(m_out_row)
            && $stable(m_out_column) && $stable(m_end_of_image))
        else $error("m_ payload changed while stalled");

    // input back pressure only comes with a result on its way out
    a_ready_low_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> m_valid)
        else $error("s_ready low without a pending result");

    // after the end of an image the next result is from row zero
    a_new_image_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_end_of_image |=> !m_valid || m_out_row == '0)
        else $error("result after end of image not from first row");

endmodule

bind cross_blur_byte_stream cbb_checker u_cbb_checker (.*);

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the cross blur byte stream filter. A driver
// feeds image bytes from a queue, a scoreboard model predicts each blurred
// byte with its row, column and end-of-image flag, and a monitor compares the
// results in order. Image sizes are reprogrammed between phases, including
// out-of-range and unused register writes, under random sender and receiver
// back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_W        = cbb_pkg::BYTE_W;
    localparam int ROW_W         = cbb_pkg::ROW_W;
    localparam int COL_W         = cbb_pkg::COL_W;
    localparam int SIZE_W        = cbb_pkg::SIZE_W;
    localparam int CFG_IDX_W     = cbb_pkg::CFG_IDX_W;
    localparam int MAX_ROW_BYTES = cbb_pkg::MAX_ROW_BYTES;
    localparam int MAX_ROWS      = cbb_pkg::MAX_ROWS;
    localparam int CHANNEL_STEP  = cbb_pkg::CHANNEL_STEP;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [SIZE_W-1:0]    SIZE_ALL_ONES = '1;
    localparam int RANDOM_ITEMS = 230;
    localparam int SETTLE_CYCLES = 16;

    typedef struct {
        logic [BYTE_W-1:0] blurred;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic              end_of_image;
    } blur_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_pixel_byte = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [BYTE_W-1:0]    m_blurred_byte;
    logic [ROW_W-1:0]     m_out_row;
    logic [COL_W-1:0]     m_out_column;
    logic                 m_end_of_image;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [SIZE_W-1:0]    cfg_wr_data = '0;

    // stimulus and scoreboard
    logic [BYTE_W-1:0] pixel_q[$];
    blur_result_t      blur_expect_q[$];
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_idle_pct = 0;
    int unsigned       bytes_queued = 0;
    int unsigned       bytes_sent = 0;
    int unsigned       results_checked = 0;
    int unsigned       images_done = 0;
    int unsigned       size_writes = 0;
    int unsigned       error_count = 0;

    // model state of the filter
    logic [SIZE_W-1:0] row_bytes_cfg = 13'd4096;
    logic [SIZE_W-1:0] row_count_cfg = 13'd4096;
    logic [BYTE_W-1:0] older_line [MAX_ROW_BYTES];
    logic [BYTE_W-1:0] newer_line [MAX_ROW_BYTES];
    int unsigned       col_pos = 0;
    int unsigned       row_pos = 0;

    cross_blur_byte_stream i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_byte   (s_pixel_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_blurred_byte (m_blurred_byte),
        .m_out_row      (m_out_row),
        .m_out_column   (m_out_column),
        .m_end_of_image (m_end_of_image),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_index   (cfg_wr_index),
        .cfg_wr_data    (cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    function automatic int unsigned used_size(input logic [SIZE_W-1:0] v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    function automatic void push_mean(input int unsigned sum, input int unsigned cnt,
                                      input int unsigned row, input int unsigned col);
        blur_result_t r;
        r.blurred      = BYTE_W'(sum / cnt);
        r.row          = ROW_W'(row);
        r.column       = COL_W'(col);
        r.end_of_image = 1'b0;
        blur_expect_q.push_back(r);
    endfunction

    // mean of a byte in the arriving bottom row
    function automatic void push_bottom_mean(input int unsigned col, input int unsigned width,
                                             input bit has_up, input int unsigned row);
        int unsigned sum;
        int unsigned cnt;
        sum = newer_line[col];
        cnt = 1;
        if (has_up) begin
            sum += older_line[col];
            cnt++;
        end
        if (col >= CHANNEL_STEP) begin
            sum += newer_line[col - CHANNEL_STEP];
            cnt++;
        end
        if (col + CHANNEL_STEP < width) begin
            sum += newer_line[col + CHANNEL_STEP];
            cnt++;
        end
        push_mean(sum, cnt, row, col);
    endfunction

    function automatic void blur_predict(input logic [BYTE_W-1:0] px);
        int unsigned width;
        int unsigned rows;
        int unsigned c;
        int unsigned rr;
        int unsigned sum;
        int unsigned cnt;
        int unsigned cc;
        int unsigned n;
        bit          is_last;
        bit          is_final;
        width    = used_size(row_bytes_cfg, MAX_ROW_BYTES);
        rows     = used_size(row_count_cfg, MAX_ROWS);
        c        = col_pos;
        rr       = row_pos;
        is_last  = (rr + 1 == rows);
        is_final = is_last && (c + 1 == width);
        n        = 0;
        if (c >= width || rr >= rows) begin
            c        = 0;
            rr       = 0;
            is_last  = (rows == 1);
            is_final = is_last && (width == 1);
        end
        // row above completes as the byte below it arrives
        if (rr >= 1) begin
            sum = newer_line[c] + px;
            cnt = 2;
            if (rr >= 2) begin
                sum += older_line[c];
                cnt++;
            end
            if (c >= CHANNEL_STEP) begin
                sum += older_line[c - CHANNEL_STEP];
                cnt++;
            end
            if (c + CHANNEL_STEP < width) begin
                sum += newer_line[c + CHANNEL_STEP];
                cnt++;
            end
            push_mean(sum, cnt, rr - 1, c);
            n++;
        end
        older_line[c] = newer_line[c];
        newer_line[c] = px;
        if (is_last) begin
            if (c >= CHANNEL_STEP) begin
                push_bottom_mean(c - CHANNEL_STEP, width, rr >= 1, rr);
                n++;
            end
            if (is_final) begin
                // flush the tail of the bottom row
                for (cc = (c >= 2) ? c - 2 : 0; cc <= c; cc++) begin
                    push_bottom_mean(cc, width, rr >= 1, rr);
                    n++;
                end
            end
        end
        if (is_final) begin
            if (n > 0) blur_expect_q[blur_expect_q.size() - 1].end_of_image = 1'b1;
            images_done++;
            col_pos = 0;
            row_pos = 0;
        end else begin
            c++;
            if (c >= width) begin
                c = 0;
                rr++;
            end
            col_pos = c;
            row_pos = rr;
        end
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                blur_predict(s_pixel_byte);
                bytes_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid      <= 1'b1;
                    s_pixel_byte <= pixel_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        blur_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (blur_expect_q.size() == 0) begin
                    report_mismatch("unexpected transaction, blurred byte", m_blurred_byte, 0);
                end else begin
                    want = blur_expect_q.pop_front();
                    results_checked++;
                    if (m_blurred_byte !== want.blurred)
                        report_mismatch("blurred_byte", m_blurred_byte, want.blurred);
                    if (m_out_row !== want.row)
                        report_mismatch("out_row", m_out_row, want.row);
                    if (m_out_column !== want.column)
                        report_mismatch("out_column", m_out_column, want.column);
                    if (m_end_of_image !== want.end_of_image)
                        report_mismatch("end_of_image", m_end_of_image, want.end_of_image);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic wait_idle();
        while (pixel_q.size() != 0 || s_valid || blur_expect_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            cbb_pkg::CFG_ROW_BYTES: begin
                row_bytes_cfg = data;
                col_pos       = 0;
                row_pos       = 0;
            end
            cbb_pkg::CFG_ROW_COUNT: begin
                row_count_cfg = data;
                col_pos       = 0;
                row_pos       = 0;
            end
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] rb, input logic [SIZE_W-1:0] rc);
        wait_idle();
        write_reg(cbb_pkg::CFG_ROW_BYTES, rb);
        write_reg(cbb_pkg::CFG_ROW_COUNT, rc);
        size_writes++;
    endtask

    task automatic queue_bytes(input int unsigned n);
        logic [BYTE_W-1:0] v;
        repeat (n) begin
            case ($urandom_range(7))
                0:       v = 8'h00;
                1:       v = 8'hFF;
                default: v = BYTE_W'($urandom_range(255));
            endcase
            pixel_q.push_back(v);
            bytes_queued++;
        end
    endtask

    task automatic queue_list(input logic [BYTE_W-1:0] vals[]);
        foreach (vals[i]) begin
            pixel_q.push_back(vals[i]);
            bytes_queued++;
        end
    endtask

    initial begin
        int unsigned directed_count;
        int unsigned progress;
        int unsigned w;
        int unsigned h;
        logic [BYTE_W-1:0] grid_top[];
        logic [BYTE_W-1:0] grid_rest[];

        grid_top  = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF};
        grid_rest = '{8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h01,
                      8'h80, 8'hFE, 8'h7F};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 8;
        recv_idle_pct = 78;

        // zero sizes clamp to a one byte image
        set_size('0, '0);
        queue_list('{8'h00, 8'hFF});

        // three rows of six bytes, paused mid image with spare index writes
        set_size(13'd6, 13'd3);
        queue_list(grid_top);
        wait_idle();
        write_reg(CFG_SPARE_A, SIZE_ALL_ONES);
        write_reg(CFG_SPARE_B, 13'h0AAA);
        queue_list(grid_rest);

        // oversize width clamps, single row
        set_size(SIZE_ALL_ONES, 13'd1);
        queue_list('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        directed_count = bytes_queued;

        while (bytes_queued < directed_count + RANDOM_ITEMS) begin
            progress = bytes_queued - directed_count;
            wait_idle();
            if (progress < RANDOM_ITEMS / 3) begin
                send_idle_pct = 8;
                recv_idle_pct = 78;
            end else if (progress < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 78;
                recv_idle_pct = 8;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(15))
                0: begin
                    set_size($urandom_range(1) ? SIZE_ALL_ONES : 13'd4096, 13'd1);
                    queue_bytes($urandom_range(4, 12));
                end
                1: begin
                    set_size(SIZE_W'($urandom_range(1, 3)),
                             $urandom_range(1) ? SIZE_ALL_ONES : 13'd4096);
                    queue_bytes($urandom_range(6, 20));
                end
                2: begin
                    if ($urandom_range(1)) begin
                        h = $urandom_range(1, 5);
                        set_size('0, SIZE_W'(h));
                        queue_bytes(h);
                    end else begin
                        w = $urandom_range(1, 9);
                        set_size(SIZE_W'(w), '0);
                        queue_bytes(w);
                    end
                end
                default: begin
                    w = $urandom_range(1, 9);
                    h = $urandom_range(1, 6);
                    set_size(SIZE_W'(w), SIZE_W'(h));
                    queue_bytes(w * h * $urandom_range(1, 2));
                    // broken image, cut short by the next size write
                    if ($urandom_range(4) == 0) queue_bytes($urandom_range(1, w * h));
                end
            endcase
        end

        wait_idle();
        $display("covered %0d input bytes, %0d complete images, %0d size settings",
                 bytes_sent, images_done, size_writes);
        $display("checked %0d blurred bytes with %0d mismatches", results_checked, error_count);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #400_000;
        $display("timeout with %0d results outstanding", blur_expect_q.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ sim.f @@
sv/cbb_pkg.sv
sv/cbb_cell.sv
sv/cbb_line_ram.sv
sv/cbb_mean.sv
sv/cross_blur_byte_stream.sv
sv/cbb_checker.sv
verif/tb_top.sv
